// ----- sv/sle_pkg.sv -----
// Package for the serial line editor: result kinds, character codes and echo text.
// Depends on nothing; used by sle_ctrl and serial_line_editor_unit.
package sle_pkg;

    // Width of the write position, the line length and the character limit.
    localparam int POS_W = 6;

    // Result kinds.
    localparam logic [1:0] KIND_ECHO = 2'd0;
    localparam logic [1:0] KIND_LINE = 2'd1;
    localparam logic [1:0] KIND_END  = 2'd2;

    // Received characters with a meaning of their own.
    localparam logic [7:0] CHAR_BS    = 8'd8;
    localparam logic [7:0] CHAR_TAB   = 8'd9;
    localparam logic [7:0] CHAR_CR    = 8'd13;
    localparam logic [7:0] CHAR_ESC   = 8'd27;
    localparam logic [7:0] CHAR_SPACE = 8'd32;
    localparam logic [7:0] CHAR_LT    = 8'h3C;
    localparam logic [7:0] CHAR_GT    = 8'h3E;

    // Echo sequences that the sequencer plays out.
    localparam logic [1:0] ECHO_PRINT = 2'd0;
    localparam logic [1:0] ECHO_BS    = 2'd1;
    localparam logic [1:0] ECHO_TAB   = 2'd2;
    localparam logic [1:0] ECHO_ESC   = 2'd3;

    // Register map of the configuration port.
    localparam logic [1:0] REG_MAX_CHARS_ADDR = 2'd0;
    localparam logic [POS_W-1:0] MAX_CHARS_RESET = 6'd20;

    // Number of beats in an echo sequence.
    function automatic logic [2:0] echo_len(input logic [1:0] code);
        logic [2:0] n;
        case (code)
            ECHO_PRINT: n = 3'd1;
            ECHO_BS:    n = 3'd3;
            ECHO_TAB:   n = 3'd5;
            ECHO_ESC:   n = 3'd5;
            default:    n = 3'd1;
        endcase
        return n;
    endfunction

    // Character at a given step of an echo sequence.
    function automatic logic [7:0] echo_char(input logic [1:0] code, input logic [2:0] idx,
                                             input logic [7:0] rx);
        logic [7:0] c;
        c = CHAR_LT;
        case (code)
            ECHO_PRINT: c = rx;
            ECHO_BS:    c = (idx == 3'd1) ? CHAR_SPACE : CHAR_BS;
            ECHO_TAB:
            begin
                case (idx)
                    3'd0:    c = CHAR_LT;
                    3'd1:    c = 8'h54;
                    3'd2:    c = 8'h41;
                    3'd3:    c = 8'h42;
                    default: c = CHAR_GT;
                endcase
            end
            ECHO_ESC:
            begin
                case (idx)
                    3'd0:    c = CHAR_LT;
                    3'd1:    c = 8'h45;
                    3'd2:    c = 8'h53;
                    3'd3:    c = 8'h43;
                    default: c = CHAR_GT;
                endcase
            end
            default: c = rx;
        endcase
        return c;
    endfunction

endpackage

// ----- sv/serial_line_editor_unit.sv -----
// A byte is taken in the idle state; the sequencer then loads its result beats into the
// output register, one beat a cycle while the output does not stall. An echoed byte gives
// its echo beats; a CR gives one beat per stored character, each from one line store read, then an end beat.
// Output stalls hold the beats. A new byte is taken only once its last beat is loaded.
// Reset: write position 0, max_chars 20, output empty; the line store is not cleared.
// Top level of the serial line editor: configuration port and sequencer.
// Depends on sle_pkg, sle_ctrl.
module serial_line_editor_unit #(
    parameter int BUFFER_DEPTH = 32
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_stall,
    input  logic [7:0]                rx_byte,
    output logic                      out_valid,
    input  logic                      out_stall,
    output logic [1:0]                kind,
    output logic [7:0]                data_byte,
    output logic [sle_pkg::POS_W-1:0] line_length,
    output logic                      last,
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [1:0]                paddr,
    input  logic [31:0]               pwdata,
    output logic [31:0]               prdata,
    output logic                      pready
);

    logic [sle_pkg::POS_W-1:0] max_chars_reg;
    logic                      cfg_write;

    // Register write on the access phase.
    assign cfg_write = psel && penable && pwrite && (paddr == sle_pkg::REG_MAX_CHARS_ADDR);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_chars_reg <= sle_pkg::MAX_CHARS_RESET;
        end
        else if (cfg_write)
        begin
            max_chars_reg <= pwdata[sle_pkg::POS_W-1:0];
        end
    end

    // Register read-back.
    always_comb
    begin
        if (paddr == sle_pkg::REG_MAX_CHARS_ADDR)
        begin
            prdata = {26'd0, max_chars_reg};
        end
        else
        begin
            prdata = '0;
        end
    end

    assign pready = 1'b1;

    // Line editing sequencer.
    sle_ctrl #(
        .BUFFER_DEPTH (BUFFER_DEPTH)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .max_chars   (max_chars_reg),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .rx_byte     (rx_byte),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .kind        (kind),
        .data_byte   (data_byte),
        .line_length (line_length),
        .last        (last)
    );

endmodule

// ----- sv/sle_line_ram.sv -----
// Line store of the serial line editor: one write port, one registered read port.
// Depends on nothing.
module sle_line_ram #(
    parameter int DEPTH  = 32,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [7:0]        wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [7:0]        rdata
);

    logic [7:0] mem [DEPTH];
    logic [7:0] rdata_reg;

    // Write port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Read port; the data holds until the next read.
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- sv/sle_ctrl.sv -----
// Sequencer of the serial line editor: decodes a byte, updates the line store and
// plays out the result beats through an output register. Depends on sle_pkg, sle_line_ram.
module sle_ctrl #(
    parameter int BUFFER_DEPTH = 32
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic [sle_pkg::POS_W-1:0] max_chars,
    input  logic                      in_valid,
    output logic                      in_stall,
    input  logic [7:0]                rx_byte,
    output logic                      out_valid,
    input  logic                      out_stall,
    output logic [1:0]                kind,
    output logic [7:0]                data_byte,
    output logic [sle_pkg::POS_W-1:0] line_length,
    output logic                      last
);

    localparam int ADDR_W = $clog2(BUFFER_DEPTH);
    localparam int PW     = sle_pkg::POS_W;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_ECHO = 2'd1;
    localparam logic [1:0] S_LINE = 2'd2;
    localparam logic [1:0] S_END  = 2'd3;

    // Control state.
    logic [1:0]    state_reg, state_next;
    logic [PW-1:0] pos_reg, pos_next;
    logic          out_valid_reg, out_valid_next;

    // Payload state.
    logic [PW-1:0] idx_reg, idx_next;
    logic [PW-1:0] len_reg, len_next;
    logic [1:0]    code_reg, code_next;
    logic [7:0]    byte_reg, byte_next;
    logic [1:0]    kind_reg, kind_next;
    logic [7:0]    data_reg, data_next;
    logic [PW-1:0] olen_reg, olen_next;
    logic          last_reg, last_next;

    logic              slot_free;
    logic              load;
    logic [PW-1:0]     limit;
    logic              mem_we;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic [7:0]        rd_data;
    logic              echo_done;

    // The line store; the sequencer takes no new byte while a line is read out,
    // so reads and writes never meet on one entry.
    sle_line_ram #(
        .DEPTH (BUFFER_DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (ADDR_W'(pos_reg)),
        .wdata (rx_byte),
        .re    (rd_en),
        .raddr (rd_addr),
        .rdata (rd_data)
    );

    // Effective limit: the character limit saturates at the store depth.
    always_comb
    begin
        if ({26'd0, max_chars} > 32'(BUFFER_DEPTH))
        begin
            limit = PW'(BUFFER_DEPTH);
        end
        else
        begin
            limit = max_chars;
        end
    end

    assign slot_free = !out_valid_reg || !out_stall;
    assign echo_done = (idx_reg[2:0] == sle_pkg::echo_len(code_reg) - 3'd1);

    // Sequencer.
    always_comb
    begin
        state_next = state_reg;
        pos_next   = pos_reg;
        idx_next   = idx_reg;
        len_next   = len_reg;
        code_next  = code_reg;
        byte_next  = byte_reg;
        kind_next  = kind_reg;
        data_next  = data_reg;
        olen_next  = olen_reg;
        last_next  = last_reg;
        load       = 1'b0;
        mem_we     = 1'b0;
        rd_en      = 1'b0;
        rd_addr    = ADDR_W'(idx_reg);

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    byte_next = rx_byte;
                    idx_next  = '0;
                    if (!rx_byte[7] && rx_byte >= sle_pkg::CHAR_SPACE)
                    begin
                        code_next  = sle_pkg::ECHO_PRINT;
                        state_next = S_ECHO;
                        if (pos_reg < limit)
                        begin
                            mem_we   = 1'b1;
                            pos_next = pos_reg + 1'b1;
                        end
                    end
                    else if (rx_byte == sle_pkg::CHAR_CR)
                    begin
                        len_next = pos_reg;
                        pos_next = '0;
                        if (pos_reg != '0)
                        begin
                            rd_en      = 1'b1;
                            rd_addr    = '0;
                            state_next = S_LINE;
                        end
                        else
                        begin
                            state_next = S_END;
                        end
                    end
                    else if (rx_byte == sle_pkg::CHAR_BS)
                    begin
                        code_next  = sle_pkg::ECHO_BS;
                        state_next = S_ECHO;
                        if (pos_reg != '0)
                        begin
                            pos_next = pos_reg - 1'b1;
                        end
                    end
                    else if (rx_byte == sle_pkg::CHAR_TAB)
                    begin
                        code_next  = sle_pkg::ECHO_TAB;
                        state_next = S_ECHO;
                    end
                    else if (rx_byte == sle_pkg::CHAR_ESC)
                    begin
                        code_next  = sle_pkg::ECHO_ESC;
                        state_next = S_ECHO;
                        pos_next   = '0;
                    end
                end
            end
            S_ECHO:
            begin
                if (slot_free)
                begin
                    load      = 1'b1;
                    kind_next = sle_pkg::KIND_ECHO;
                    data_next = sle_pkg::echo_char(code_reg, idx_reg[2:0], byte_reg);
                    olen_next = '0;
                    last_next = echo_done;
                    idx_next  = idx_reg + 1'b1;
                    if (echo_done)
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            S_LINE:
            begin
                // One stored character a beat; the next read goes out with it.
                if (slot_free)
                begin
                    load      = 1'b1;
                    kind_next = sle_pkg::KIND_LINE;
                    data_next = rd_data;
                    olen_next = '0;
                    last_next = 1'b0;
                    if (({1'b0, idx_reg} + 7'd1) < {1'b0, len_reg})
                    begin
                        rd_en    = 1'b1;
                        rd_addr  = ADDR_W'(idx_reg + 1'b1);
                        idx_next = idx_reg + 1'b1;
                    end
                    else
                    begin
                        state_next = S_END;
                    end
                end
            end
            S_END:
            begin
                if (slot_free)
                begin
                    load       = 1'b1;
                    kind_next  = sle_pkg::KIND_END;
                    data_next  = '0;
                    olen_next  = len_reg;
                    last_next  = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // The output beat stays until it is taken.
    assign out_valid_next = load ? 1'b1 : (out_valid_reg && out_stall);

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            pos_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pos_reg       <= pos_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        idx_reg  <= idx_next;
        len_reg  <= len_next;
        code_reg <= code_next;
        byte_reg <= byte_next;
        kind_reg <= kind_next;
        data_reg <= data_next;
        olen_reg <= olen_next;
        last_reg <= last_next;
    end

    assign in_stall    = (state_reg != S_IDLE);
    assign out_valid   = out_valid_reg;
    assign kind        = kind_reg;
    assign data_byte   = data_reg;
    assign line_length = olen_reg;
    assign last        = last_reg;

    // The write position never passes the store depth.
    a_pos_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        {26'd0, pos_reg} <= 32'(BUFFER_DEPTH))
        else $error("write position beyond the line store");

    // The store is written only when a byte is taken.
    a_write_on_accept: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> (state_reg == S_IDLE && in_valid))
        else $error("line store written outside a byte accept");

    // During readout the read index stays inside the line.
    a_idx_in_line: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_LINE) |-> (idx_reg < len_reg))
        else $error("readout index past the line length");

    // An end marker is always the final beat of its byte.
    a_end_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && kind_reg == sle_pkg::KIND_END) |-> last_reg)
        else $error("end marker without final flag");

endmodule
